### hdl/ui_mix_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ui_mix_pkg
// Shared codes, constants and types of the UI voice mixer.
// ----------------------------------------------------------------------------
package ui_mix_pkg;

  localparam logic [1:0] CMD_TRIGGER = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_WRITE   = 2'd2;
  localparam logic [1:0] CMD_SOUND   = 2'd3;

  localparam logic CFG_NAV  = 1'b0;
  localparam logic CFG_BOOT = 1'b1;

  localparam logic [2:0] FREE_VOICE = 3'd7;
  localparam logic [2:0] BOOT_SOUND = 3'd5;

  localparam int GAIN_W     = 29;
  localparam int MUL_W      = 30;
  localparam int PROD_W     = 60;
  localparam int ADDR_SUM_W = 18;

  localparam logic [GAIN_W-1:0] SLEW_STEP  = 29'd25600;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 29'd655360;
  localparam logic [11:0]       TGT_RESET  = 12'd10;
  localparam logic [6:0]        EDGE_FRAMES = 7'd96;

  // reciprocals for /3, /25 and /125 after the power-of-two part is shifted out
  localparam logic [MUL_W-1:0] RECIP3   = 30'd43691;
  localparam logic [MUL_W-1:0] RECIP25  = 30'd671089;
  localparam logic [MUL_W-1:0] RECIP125 = 30'd4294968;
  localparam int RECIP3_SH   = 17;
  localparam int RECIP25_SH  = 24;
  localparam int RECIP125_SH = 29;
  localparam logic [43:0] SAT_LIMIT = 44'd32768000;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_VCHK = 13'b0000000000010,
    S_WRAP = 13'b0000000000100,
    S_M1   = 13'b0000000001000,
    S_M2   = 13'b0000000010000,
    S_M3   = 13'b0000000100000,
    S_M4   = 13'b0000001000000,
    S_M5   = 13'b0000010000000,
    S_F1   = 13'b0000100000000,
    S_F2   = 13'b0001000000000,
    S_F3   = 13'b0010000000000,
    S_F4   = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } mix_state_t;

  function automatic logic [8:0] sound_gain(input logic [2:0] s);
    logic [8:0] g;
    begin
      case (s)
        3'd1:    g = 9'd350;
        3'd5:    g = 9'd105;
        default: g = 9'd200;
      endcase
      return g;
    end
  endfunction

endpackage
`default_nettype wire

### hdl/ui_mix_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ui_mix_if
// Valid/ready channels for mixer commands and mixed frames.
// ----------------------------------------------------------------------------
interface ui_mix_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         event_id;
  logic [15:0]        address;
  logic [16:0]        length;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;
  modport source(output valid, command, event_id, address, length, left_in, right_in,
                 input ready);
  modport sink(input valid, command, event_id, address, length, left_in, right_in,
               output ready);
endinterface

interface ui_mix_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               active;
  modport source(output valid, left_out, right_out, active, input ready);
  modport sink(input valid, left_out, right_out, active, output ready);
endinterface
`default_nettype wire

### hdl/ui_mix_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ui_mix_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ui_mix_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### hdl/ui_mix_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ui_mix_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ui_mix_mul (
  input  wire logic                     clk,
  input  wire logic signed [29:0]       a,
  input  wire logic signed [29:0]       b,
  output logic signed [59:0]            p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

### hdl/ui_sound_voice_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ui_sound_voice_mixer
// Stereo mixer of up to VOICE_COUNT voices playing sounds from sample memory.
// ----------------------------------------------------------------------------
// Commands arrive on in_ch; a tick command returns one mixed frame on out_ch,
// every other command returns nothing. cfg_we writes the bus gain targets
// (index 0 navigation, 1 start-up); the user must only use it while the block
// is idle, which the block itself does not enforce. Trigger and sound entry
// commands are handled in the idle state. A sample write waits in S_WRAP,
// subtracting FRAME_DEPTH from the address until it is in range, then writes.
// A tick walks the voices one at a time in S_VCHK; for a playing voice the
// address is wrapped in S_WRAP and each channel scaled in S_M1 to S_M5, then
// each output channel is formed in S_F1 to S_F4. Every scaling step of every
// channel goes through the one shared multiplier, one product per cycle.
// in_ch.ready is low while a write or a tick is in progress.
// Reset frees all voices, clears the sound table and sets both bus gains to
// 655360; sample memory is not cleared and holds nothing until written.
// A finished frame sits in the output register; if the receiver stalls, the
// block keeps accepting triggers and entries, and a further tick waits at its
// end until the previous frame has been taken.
// ----------------------------------------------------------------------------
module ui_sound_voice_mixer #(
  parameter int VOICE_COUNT = 16,
  parameter int FRAME_DEPTH = 65536,
  parameter int SOUND_COUNT = 7
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  ui_mix_in_if.sink         in_ch,
  ui_mix_out_if.source      out_ch,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [11:0]  cfg_data
);
  import ui_mix_pkg::*;

  localparam int VIW   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int CMP_W = (AW + 1 > ADDR_SUM_W) ? AW + 1 : ADDR_SUM_W;
  localparam int ACC_W = $clog2(VOICE_COUNT) + 18;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(FRAME_DEPTH);
  localparam logic [VIW-1:0]   LAST_V  = VIW'(VOICE_COUNT - 1);

  mix_state_t state_r, state_nxt;

  logic [11:0]       nav_tgt_r, boot_tgt_r;
  logic [GAIN_W-1:0] nav_gain_r, boot_gain_r;
  logic [15:0]       sound_start_r [SOUND_COUNT];
  logic [16:0]       sound_len_r   [SOUND_COUNT];
  logic [2:0]        voice_snd_r   [VOICE_COUNT];
  logic [16:0]       voice_pos_r   [VOICE_COUNT];

  logic [VIW-1:0]    vi_r;
  logic              ch_r;
  logic [CMP_W-1:0]  addr_r;
  logic              is_write_r;
  logic [31:0]       wdata_r;
  logic [6:0]        ramp_r;
  logic [2:0]        snd_r;
  logic              neg_r;
  logic              sat_r;
  logic signed [PROD_W-1:0] sum_r;
  logic signed [ACC_W-1:0]  nav_acc_r  [2];
  logic signed [ACC_W-1:0]  boot_acc_r [2];
  logic              active_r;
  logic signed [15:0] res_l_r, res_r_r;
  logic              out_valid_r;
  logic signed [15:0] out_left_r, out_right_r;
  logic              out_active_r;

  logic              in_acc;
  logic              free_found;
  logic [VIW-1:0]    free_idx;
  logic [2:0]        cur_snd;
  logic [16:0]       cur_pos, cur_len, cur_rem, cur_edge;
  logic              snd_ok;
  logic [31:0]       ram_rdata;
  logic signed [15:0] smp;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p, abs_p, sum_s, abs_s;
  logic [43:0]       t_s;
  logic [15:0]       q_f;
  logic [16:0]       v_mag;
  logic signed [ACC_W-1:0] v_s;
  logic              wrap_ok;

  function automatic logic [GAIN_W-1:0] slew(input logic [GAIN_W-1:0] now,
                                             input logic [11:0] tgt_reg);
    logic [GAIN_W-1:0] tgt;
    logic [GAIN_W-1:0] r;
    begin
      tgt = GAIN_W'({tgt_reg, 16'h0000});
      r   = now;
      if (now < tgt) begin
        r = (tgt - now > SLEW_STEP) ? now + SLEW_STEP : tgt;
      end else if (now > tgt) begin
        r = (now - tgt > SLEW_STEP) ? now - SLEW_STEP : tgt;
      end
      return r;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic neg, input logic sat,
                                               input logic [15:0] q);
    logic signed [15:0] r;
    begin
      if (sat) begin
        r = neg ? 16'sh8000 : 16'sh7FFF;
      end else begin
        r = neg ? -signed'(q) : signed'(q);
      end
      return r;
    end
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_left_r;
  assign out_ch.right_out = out_right_r;
  assign out_ch.active    = out_active_r;

  // lowest-numbered free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (voice_snd_r[i] == FREE_VOICE) begin
        free_found = 1'b1;
        free_idx   = VIW'(i);
      end
    end
  end

  assign cur_snd  = voice_snd_r[vi_r];
  assign cur_pos  = voice_pos_r[vi_r];
  assign snd_ok   = (32'(cur_snd) < SOUND_COUNT);
  assign cur_len  = snd_ok ? sound_len_r[cur_snd] : 17'd0;
  assign cur_rem  = cur_len - 17'd1 - cur_pos;
  assign cur_edge = (cur_pos < cur_rem) ? cur_pos : cur_rem;
  assign wrap_ok  = (addr_r < DEPTH_C);

  assign smp   = ch_r ? signed'(ram_rdata[31:16]) : signed'(ram_rdata[15:0]);
  assign abs_p = (mul_p < 0) ? -mul_p : mul_p;
  assign sum_s = sum_r + mul_p;
  assign abs_s = (sum_s < 0) ? -sum_s : sum_s;
  assign t_s   = abs_s[59:16];
  assign q_f   = mul_p[RECIP125_SH+15:RECIP125_SH];
  assign v_mag = mul_p[RECIP25_SH+16:RECIP25_SH];
  assign v_s   = neg_r ? -ACC_W'(v_mag) : ACC_W'(v_mag);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M1: begin
        mul_a = MUL_W'(smp);
        mul_b = MUL_W'(ramp_r);
      end
      S_M2: begin
        mul_a = MUL_W'(abs_p >>> 5);
        mul_b = RECIP3;
      end
      S_M3: begin
        mul_a = MUL_W'(abs_p >>> RECIP3_SH);
        mul_b = MUL_W'(sound_gain(snd_r));
      end
      S_M4: begin
        mul_a = MUL_W'(mul_p >>> 3);
        mul_b = RECIP25;
      end
      S_F1: begin
        mul_a = MUL_W'(nav_acc_r[ch_r]);
        mul_b = MUL_W'(nav_gain_r);
      end
      S_F2: begin
        mul_a = MUL_W'(boot_acc_r[ch_r]);
        mul_b = MUL_W'(boot_gain_r);
      end
      S_F3: begin
        mul_a = MUL_W'(t_s >> 3);
        mul_b = RECIP125;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ui_mix_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ui_mix_ram #(
    .WIDTH (32),
    .DEPTH (FRAME_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    ((state_r == S_WRAP) && wrap_ok && is_write_r),
    .waddr (addr_r[AW-1:0]),
    .wdata (wdata_r),
    .re    ((state_r == S_WRAP) && wrap_ok && !is_write_r),
    .raddr (addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.command == CMD_TICK) begin
          state_nxt = S_VCHK;
        end else if (in_acc && in_ch.command == CMD_WRITE) begin
          state_nxt = S_WRAP;
        end
      end
      S_VCHK: begin
        if (snd_ok && cur_pos < cur_len) begin
          state_nxt = S_WRAP;
        end else if (vi_r == LAST_V) begin
          state_nxt = S_F1;
        end
      end
      S_WRAP: begin
        if (wrap_ok) begin
          state_nxt = is_write_r ? S_IDLE : S_M1;
        end
      end
      S_M1: state_nxt = S_M2;
      S_M2: state_nxt = S_M3;
      S_M3: state_nxt = S_M4;
      S_M4: state_nxt = S_M5;
      S_M5: begin
        if (!ch_r) begin
          state_nxt = S_M1;
        end else if (vi_r == LAST_V) begin
          state_nxt = S_F1;
        end else begin
          state_nxt = S_VCHK;
        end
      end
      S_F1: state_nxt = S_F2;
      S_F2: state_nxt = S_F3;
      S_F3: state_nxt = S_F4;
      S_F4: state_nxt = ch_r ? S_DONE : S_F1;
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nav_tgt_r    <= TGT_RESET;
      boot_tgt_r   <= TGT_RESET;
      nav_gain_r   <= GAIN_RESET;
      boot_gain_r  <= GAIN_RESET;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SOUND_COUNT; i++) begin
        sound_start_r[i] <= '0;
        sound_len_r[i]   <= '0;
      end
      for (int i = 0; i < VOICE_COUNT; i++) begin
        voice_snd_r[i] <= FREE_VOICE;
        voice_pos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        if (cfg_index == CFG_NAV) begin
          nav_tgt_r <= cfg_data;
        end else begin
          boot_tgt_r <= cfg_data;
        end
      end

      // load a new frame, or drop the one just taken
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_ch.command)
              CMD_TRIGGER: begin
                if (32'(in_ch.event_id) < SOUND_COUNT && free_found) begin
                  voice_snd_r[free_idx] <= in_ch.event_id;
                  voice_pos_r[free_idx] <= '0;
                end
              end
              CMD_TICK: begin
                nav_gain_r  <= slew(nav_gain_r, nav_tgt_r);
                boot_gain_r <= slew(boot_gain_r, boot_tgt_r);
              end
              CMD_SOUND: begin
                if (32'(in_ch.event_id) < SOUND_COUNT) begin
                  sound_start_r[in_ch.event_id] <= in_ch.address;
                  sound_len_r[in_ch.event_id]   <= in_ch.length;
                end
              end
              default: ;
            endcase
          end
        end
        S_VCHK: begin
          // drop a voice that has reached its end
          if (snd_ok && cur_pos >= cur_len) begin
            voice_snd_r[vi_r] <= FREE_VOICE;
          end
        end
        S_M5: begin
          if (ch_r) begin
            voice_pos_r[vi_r] <= cur_pos + 17'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        vi_r       <= '0;
        ch_r       <= 1'b0;
        active_r   <= 1'b0;
        is_write_r <= 1'b1;
        addr_r     <= CMP_W'(in_ch.address);
        wdata_r    <= {in_ch.right_in, in_ch.left_in};
        for (int c = 0; c < 2; c++) begin
          nav_acc_r[c]  <= '0;
          boot_acc_r[c] <= '0;
        end
      end
      S_VCHK: begin
        if (snd_ok && cur_pos < cur_len) begin
          active_r   <= 1'b1;
          snd_r      <= cur_snd;
          ramp_r     <= (cur_edge < 17'(EDGE_FRAMES)) ? cur_edge[6:0] : EDGE_FRAMES;
          addr_r     <= CMP_W'({2'b00, sound_start_r[cur_snd]} + {1'b0, cur_pos});
          is_write_r <= 1'b0;
          ch_r       <= 1'b0;
        end else if (vi_r != LAST_V) begin
          vi_r <= vi_r + VIW'(1);
        end else begin
          ch_r <= 1'b0;
        end
      end
      S_WRAP: begin
        if (!wrap_ok) begin
          addr_r <= addr_r - DEPTH_C;
        end
      end
      S_M2: neg_r <= (mul_p < 0);
      S_M5: begin
        if (snd_r == BOOT_SOUND) begin
          boot_acc_r[ch_r] <= boot_acc_r[ch_r] + v_s;
        end else begin
          nav_acc_r[ch_r] <= nav_acc_r[ch_r] + v_s;
        end
        ch_r <= !ch_r;
        if (ch_r && vi_r != LAST_V) begin
          vi_r <= vi_r + VIW'(1);
        end
      end
      S_F2: sum_r <= mul_p;
      S_F3: begin
        neg_r <= (sum_s < 0);
        sat_r <= (t_s >= SAT_LIMIT);
      end
      S_F4: begin
        ch_r <= !ch_r;
        if (ch_r) begin
          res_r_r <= sat16(neg_r, sat_r, q_f);
        end else begin
          res_l_r <= sat16(neg_r, sat_r, q_f);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_left_r   <= res_l_r;
          out_right_r  <= res_r_r;
          out_active_r <= active_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/ui_mix_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ui_mix_checker
// Port-level checks on the UI voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
module ui_mix_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         in_command,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_left,
  input wire logic signed [15:0] out_right
);
  import ui_mix_pkg::*;

  // a held frame stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("held frame changed before transaction");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("frame valid after reset");

  // a tick starts the voice walk and blocks further commands
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_TICK |=> !in_ready)
    else $error("command taken during tick");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_WRITE |=> !in_ready)
    else $error("command taken during sample write");

endmodule

bind ui_sound_voice_mixer ui_mix_checker u_ui_mix_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_command (in_ch.command),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_left   (out_ch.left_out),
  .out_right  (out_ch.right_out)
);
`default_nettype wire
